### design/bra_pkg.sv
// Shared types, constants and helper functions of the buddy range allocator.
package bra_pkg;

	localparam int MIN_CLASS_DEF = 8;
	localparam int MAX_CLASS_DEF = 16;
	localparam int ARENA_LOG_DEF = 20;
	localparam int QUANTUM_LOG   = 8;
	localparam int CLASS_W       = 6;
	localparam int WORD_W        = 32;
	localparam int REQ_W         = 21;
	localparam int FIRST_W       = 20;
	localparam int CAP_W         = 17;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_RANGE = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	localparam logic OP_ACQUIRE = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	typedef struct packed {
		logic               operation;
		logic [REQ_W-1:0]   request_vertices;
		logic [FIRST_W-1:0] block_first;
		logic [CAP_W-1:0]   block_capacity;
	} in_word_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [FIRST_W-1:0] first_vertex;
		logic [CAP_W-1:0]   capacity_vertices;
	} out_word_t;

	function automatic logic [4:0] lsb32(input logic [WORD_W-1:0] w);
		logic [4:0] r;
		r = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (w[i]) begin
				r = 5'(i);
			end
		end
		return r;
	endfunction

	function automatic logic [CLASS_W-1:0] tz17(input logic [CAP_W-1:0] v);
		logic [CLASS_W-1:0] r;
		r = CLASS_W'(CAP_W);
		for (int i = CAP_W - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = CLASS_W'(i);
			end
		end
		return r;
	endfunction

endpackage

### design/bra_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bra_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### design/bra_seq.sv
// Sequencer for acquire and release over the free-mark memory and the tail.
module bra_seq import bra_pkg::*; #(
	parameter int MIN_CLASS = MIN_CLASS_DEF,
	parameter int MAX_CLASS = MAX_CLASS_DEF,
	parameter int ARENA_LOG = ARENA_LOG_DEF,
	localparam int BW = ARENA_LOG - MIN_CLASS + 1,
	localparam int AW = BW - 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  in_word_t          request,
	output logic              busy,
	output logic              done,
	output out_word_t         result,
	output logic [AW-1:0]     ram_raddr,
	input  logic [WORD_W-1:0] ram_rdata,
	output logic              ram_we,
	output logic [AW-1:0]     ram_waddr,
	output logic [WORD_W-1:0] ram_wdata
);

	localparam int TOP_CLASS = (MAX_CLASS < ARENA_LOG) ? MAX_CLASS : ARENA_LOG;
	localparam int HW = ARENA_LOG + 1;
	localparam int CW = CLASS_W;

	typedef enum logic [4:0] {
		IDLE, DECODE, SCAN_INIT, SCAN_RD, SCAN_CHK, FOUND, SPLIT, TAIL_ALIGN,
		TAIL_CHK, GAP, MERGE, MERGE_R, MERGE_C, FINAL, TRIM_START, TRIM, TRIM_R,
		TRIM_C, SET_RD, SET_WR, GRANT
	} state_t;

	state_t                 state_q, ret_q;
	in_word_t               req_q;
	logic [CW-1:0]          cls_q, mcls_q, j_q, s_q;
	logic [ARENA_LOG-1:0]   midx_q, idx_q, first_q;
	logic [HW-1:0]          hw_q, gap_q, aligned_q;
	logic [AW-1:0]          scan_w_q;
	out_word_t              result_q;
	logic                   done_q;

	logic [BW:0]            fm_full, one_sh;
	logic [BW-1:0]          base_m, last_m, mark_b, found_b, found_idx;
	logic [AW-1:0]          mark_w;
	logic [WORD_W-1:0]      bit_mask, lo_mask, hi_mask, hits, pos_mask;
	logic [4:0]             pos;
	logic [CW-1:0]          acq_c, rel_c;
	logic [HW-1:0]          cap_h, span;
	logic                   gap_bit, mark_hit, align_bad, beyond;

	always_comb begin
		fm_full   = {1'b1, {BW{1'b0}}};
		one_sh    = (BW+1)'(1) << (CW'(ARENA_LOG + 1) - mcls_q);
		base_m    = BW'(fm_full - one_sh);
		last_m    = BW'(fm_full - (one_sh >> 1) - (BW+1)'(1));
		mark_b    = base_m + midx_q[BW-1:0];
		mark_w    = mark_b[BW-1:5];
		bit_mask  = WORD_W'(1) << mark_b[4:0];
		mark_hit  = |(ram_rdata & bit_mask);
		lo_mask   = (scan_w_q == base_m[BW-1:5]) ? ({WORD_W{1'b1}} << base_m[4:0])
			: {WORD_W{1'b1}};
		hi_mask   = (scan_w_q == last_m[BW-1:5])
			? ~({{(WORD_W-1){1'b1}}, 1'b0} << last_m[4:0]) : {WORD_W{1'b1}};
		hits      = ram_rdata & lo_mask & hi_mask;
		pos       = lsb32(hits);
		pos_mask  = WORD_W'(1) << pos;
		found_b   = {scan_w_q, pos};
		found_idx = found_b - base_m;
		cap_h     = HW'(1) << cls_q;
		span      = HW'(1) << j_q;
		gap_bit   = |(gap_q & span);

		acq_c = CW'(QUANTUM_LOG);
		for (int k = QUANTUM_LOG; k < REQ_W; k++) begin
			if (req_q.request_vertices > (REQ_W'(1) << k)) begin
				acq_c = CW'(k + 1);
			end
		end
		rel_c     = tz17(req_q.block_capacity);
		align_bad = (32'(req_q.block_first) & ((32'(1) << rel_c) - 32'd1)) != 32'd0;
		beyond    = (32'(req_q.block_first) >> ARENA_LOG) != 32'd0;
	end

	always_comb begin
		ram_raddr = mark_w;
		ram_we    = 1'b0;
		ram_waddr = mark_w;
		ram_wdata = ram_rdata & ~bit_mask;
		unique case (state_q)
			SCAN_RD: begin
				ram_raddr = scan_w_q;
			end
			SCAN_CHK: begin
				ram_raddr = scan_w_q + AW'(1);
				ram_we    = hits != '0;
				ram_waddr = scan_w_q;
				ram_wdata = ram_rdata & ~pos_mask;
			end
			SET_WR: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata | bit_mask;
			end
			MERGE_C, TRIM_C: begin
				ram_we = mark_hit;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= IDLE;
			ret_q     <= IDLE;
			req_q     <= '0;
			cls_q     <= '0;
			mcls_q    <= CW'(MIN_CLASS);
			j_q       <= '0;
			s_q       <= '0;
			midx_q    <= '0;
			idx_q     <= '0;
			first_q   <= '0;
			hw_q      <= '0;
			gap_q     <= '0;
			aligned_q <= '0;
			scan_w_q  <= '0;
			result_q  <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				IDLE: begin
					if (accept) begin
						req_q   <= request;
						state_q <= DECODE;
					end
				end
				DECODE: begin
					result_q <= '0;
					unique case (req_q.operation)
						OP_ACQUIRE: begin
							if (acq_c < CW'(MIN_CLASS) || acq_c > CW'(MAX_CLASS)) begin
								result_q.status <= STATUS_RANGE;
								done_q          <= 1'b1;
								state_q         <= IDLE;
							end else if (acq_c > CW'(ARENA_LOG)) begin
								result_q.status <= STATUS_FULL;
								done_q          <= 1'b1;
								state_q         <= IDLE;
							end else begin
								cls_q   <= acq_c;
								mcls_q  <= acq_c;
								state_q <= SCAN_INIT;
							end
						end
						OP_RELEASE: begin
							if (req_q.block_capacity == '0) begin
								done_q  <= 1'b1;
								state_q <= IDLE;
							end else if (rel_c < CW'(MIN_CLASS) || rel_c > CW'(MAX_CLASS)) begin
								result_q.status <= STATUS_RANGE;
								done_q          <= 1'b1;
								state_q         <= IDLE;
							end else if (rel_c > CW'(ARENA_LOG) || align_bad || beyond) begin
								done_q  <= 1'b1;
								state_q <= IDLE;
							end else begin
								cls_q   <= rel_c;
								idx_q   <= ARENA_LOG'(32'(req_q.block_first) >> rel_c);
								state_q <= MERGE;
							end
						end
						default: begin
							state_q <= IDLE;
						end
					endcase
				end
				SCAN_INIT: begin
					scan_w_q <= base_m[BW-1:5];
					state_q  <= SCAN_RD;
				end
				SCAN_RD: begin
					state_q <= SCAN_CHK;
				end
				SCAN_CHK: begin
					if (hits != '0) begin
						idx_q   <= ARENA_LOG'(found_idx);
						state_q <= FOUND;
					end else if (scan_w_q == last_m[BW-1:5]) begin
						if (mcls_q == CW'(TOP_CLASS)) begin
							state_q <= TAIL_ALIGN;
						end else begin
							mcls_q  <= mcls_q + CW'(1);
							state_q <= SCAN_INIT;
						end
					end else begin
						scan_w_q <= scan_w_q + AW'(1);
					end
				end
				FOUND: begin
					first_q <= idx_q << mcls_q;
					s_q     <= mcls_q;
					state_q <= (mcls_q == cls_q) ? GRANT : SPLIT;
				end
				SPLIT: begin
					if (s_q > cls_q) begin
						mcls_q  <= s_q - CW'(1);
						midx_q  <= (first_q >> (s_q - CW'(1))) | ARENA_LOG'(1);
						s_q     <= s_q - CW'(1);
						ret_q   <= SPLIT;
						state_q <= SET_RD;
					end else begin
						state_q <= GRANT;
					end
				end
				TAIL_ALIGN: begin
					aligned_q <= (hw_q + cap_h - HW'(1)) & ~(cap_h - HW'(1));
					state_q   <= TAIL_CHK;
				end
				TAIL_CHK: begin
					if (({1'b0, aligned_q} + {1'b0, cap_h}) > ((HW+1)'(1) << ARENA_LOG)) begin
						result_q.status <= STATUS_FULL;
						done_q          <= 1'b1;
						state_q         <= IDLE;
					end else begin
						gap_q   <= hw_q;
						j_q     <= '0;
						state_q <= GAP;
					end
				end
				GAP: begin
					if (j_q == cls_q || (gap_bit && (j_q < CW'(MIN_CLASS)
							|| j_q > CW'(MAX_CLASS)))) begin
						hw_q    <= aligned_q + cap_h;
						first_q <= aligned_q[ARENA_LOG-1:0];
						state_q <= GRANT;
					end else if (gap_bit) begin
						mcls_q  <= j_q;
						midx_q  <= ARENA_LOG'(gap_q >> j_q);
						gap_q   <= gap_q + span;
						j_q     <= j_q + CW'(1);
						ret_q   <= GAP;
						state_q <= SET_RD;
					end else begin
						j_q <= j_q + CW'(1);
					end
				end
				MERGE: begin
					if (cls_q < CW'(TOP_CLASS)) begin
						mcls_q  <= cls_q;
						midx_q  <= idx_q ^ ARENA_LOG'(1);
						state_q <= MERGE_R;
					end else begin
						state_q <= FINAL;
					end
				end
				MERGE_R: begin
					state_q <= MERGE_C;
				end
				MERGE_C: begin
					if (mark_hit) begin
						idx_q   <= idx_q >> 1;
						cls_q   <= cls_q + CW'(1);
						state_q <= MERGE;
					end else begin
						state_q <= FINAL;
					end
				end
				FINAL: begin
					mcls_q  <= cls_q;
					midx_q  <= idx_q;
					ret_q   <= TRIM_START;
					state_q <= SET_RD;
				end
				TRIM_START: begin
					j_q     <= CW'(TOP_CLASS);
					state_q <= TRIM;
				end
				TRIM: begin
					if (hw_q >= span && (hw_q & (span - HW'(1))) == '0) begin
						mcls_q  <= j_q;
						midx_q  <= ARENA_LOG'((hw_q - span) >> j_q);
						state_q <= TRIM_R;
					end else if (j_q == CW'(MIN_CLASS)) begin
						done_q  <= 1'b1;
						state_q <= IDLE;
					end else begin
						j_q <= j_q - CW'(1);
					end
				end
				TRIM_R: begin
					state_q <= TRIM_C;
				end
				TRIM_C: begin
					if (mark_hit) begin
						hw_q    <= hw_q - span;
						state_q <= TRIM_START;
					end else if (j_q == CW'(MIN_CLASS)) begin
						done_q  <= 1'b1;
						state_q <= IDLE;
					end else begin
						j_q     <= j_q - CW'(1);
						state_q <= TRIM;
					end
				end
				SET_RD: begin
					state_q <= SET_WR;
				end
				SET_WR: begin
					state_q <= ret_q;
				end
				GRANT: begin
					result_q.status            <= STATUS_OK;
					result_q.first_vertex      <= FIRST_W'(32'(first_q));
					result_q.capacity_vertices <= CAP_W'(32'(1) << cls_q);
					done_q                     <= 1'b1;
					state_q                    <= IDLE;
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign busy   = state_q != IDLE;
	assign done   = done_q;
	assign result = result_q;

endmodule

### design/buddy_range_allocator.sv
// Top level: free-mark memory, clearing pass after reset and request sequencer.
// Each word is decoded first, and a rejected word ends there. An acquire scans the free-mark
// words class by class from its own class upward, then splits a larger hit down level by level,
// or else takes the aligned tail and marks the gap pieces free; a release merges with free buddies
// level by level, marks the block free and trims the tail. One word at a time, set by the single
// memory port: busy stays high until the strobe. Reset: all free marks are cleared before a word is taken.
module buddy_range_allocator import bra_pkg::*; #(
	parameter int MIN_CLASS = MIN_CLASS_DEF,
	parameter int MAX_CLASS = MAX_CLASS_DEF,
	parameter int ARENA_LOG = ARENA_LOG_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  in_word_t  request,
	output logic      busy,
	output logic      done,
	output out_word_t result
);

	localparam int BW    = ARENA_LOG - MIN_CLASS + 1;
	localparam int AW    = BW - 5;
	localparam int DEPTH = 1 << AW;

	logic [AW:0]         clr_q;
	logic                clearing, seq_busy, accept;
	logic [AW-1:0]       s_raddr, s_waddr, m_waddr;
	logic [WORD_W-1:0]   s_wdata, m_wdata, rdata;
	logic                s_we, m_we;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (clearing) begin
			clr_q <= clr_q + (AW+1)'(1);
		end
	end

	assign clearing = !clr_q[AW];
	assign busy     = clearing || seq_busy;
	assign accept   = start && !busy;
	assign m_we     = clearing || s_we;
	assign m_waddr  = clearing ? clr_q[AW-1:0] : s_waddr;
	assign m_wdata  = clearing ? '0 : s_wdata;

	bra_ram #(
		.WIDTH(WORD_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (m_we),
		.waddr(m_waddr),
		.wdata(m_wdata),
		.raddr(s_raddr),
		.rdata(rdata)
	);

	bra_seq #(
		.MIN_CLASS(MIN_CLASS),
		.MAX_CLASS(MAX_CLASS),
		.ARENA_LOG(ARENA_LOG)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.request  (request),
		.busy     (seq_busy),
		.done     (done),
		.result   (result),
		.ram_raddr(s_raddr),
		.ram_rdata(rdata),
		.ram_we   (s_we),
		.ram_waddr(s_waddr),
		.ram_wdata(s_wdata)
	);

endmodule

### design/bra_check.sv
// Port-level checks of the allocator, bound to the top level.
module bra_check import bra_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input in_word_t  request,
	input logic      busy,
	input logic      done,
	input out_word_t result
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe lasted more than one cycle");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while still busy");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.status == STATUS_OK || result.status == STATUS_RANGE
			|| result.status == STATUS_FULL)
		else $error("undefined status code");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status != STATUS_OK |->
			result.first_vertex == '0 && result.capacity_vertices == '0)
		else $error("failed request carried a block");

endmodule

bind buddy_range_allocator bra_check u_bra_check (.*);
